[rtl/core/dptb_pkg.sv]
package dptb_pkg;

   localparam int TABLE_DEPTH = 512;
   localparam int SLOT_W      = 10;
   localparam int INDEX_W     = 9;
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 16;
   localparam int LEN_W       = 32;
   localparam int MAX_RES     = 5;
   localparam int RES_CNT_W   = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 64;

   localparam logic [SLOT_W-1:0] ENTRIES_RESET = SLOT_W'(512);

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_ENTRIES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BB_ADDR       = 1'b1;

   typedef enum logic {
      KIND_DESC   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_MISMATCH = 2'd2
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [INDEX_W-1:0]   idx;
      logic [ADDR_W-1:0]    addr;
      logic [COUNT_W-1:0]   count;
      logic                 mark;
      status_type           status;
   } result_type;

   typedef struct packed {
      result_type [MAX_RES-1:0] item;
      logic [RES_CNT_W-1:0]     count;
   } res_list_type;

   function automatic result_type make_desc(input logic [SLOT_W-1:0]  slot,
                                            input logic [ADDR_W-1:0]  addr,
                                            input logic [COUNT_W-1:0] count,
                                            input logic               mark);
      result_type r;
      r.kind   = KIND_DESC;
      r.idx    = slot[INDEX_W-1:0];
      r.addr   = addr;
      r.count  = count;
      r.mark   = mark;
      r.status = ST_OK;
      return r;
   endfunction

   function automatic result_type make_status(input status_type st);
      result_type r;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = st;
      return r;
   endfunction

endpackage

[rtl/core/dma_prd_table_builder.sv]
// channel   direction  tdata (low bit up)                          tuser  tlast
// req_      in         seg_addr, seg_len, request_length            -      seg_last
// rsp_      out        desc_index, desc_addr, desc_count,           kind   run_last
//                      end_mark, status, zero pad to 64
// csr_      in         write enable, index, 32-bit data             -      -
//
// A segment is registered, expanded combinationally into up to five results,
// then the result buffer drains one transaction per cycle. The next segment
// is taken while the last result of the previous one is being handed off;
// segments that give no result pass at one per cycle.
// Reset is synchronous and clears control state and the request state.
// A stall on rsp_ holds the buffer; the input register then holds too, unless its segment gives no result.
module dma_prd_table_builder import dptb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // seg_addr, seg_len, request_length
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // desc_index, desc_addr, desc_count,
                                              // end_mark, status, pad
   output logic [0:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SLOT_W-1:0] table_entries_ff;
   logic [ADDR_W-1:0] bb_addr_ff;
   logic              emit_ready;
   logic              emit_load;
   res_list_type      res_list;
   result_type        out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_entries_ff <= ENTRIES_RESET;
         bb_addr_ff       <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TABLE_ENTRIES: table_entries_ff <= csr_wdata[SLOT_W-1:0];
            CSR_BB_ADDR:       bb_addr_ff       <= csr_wdata;
            default:           ;
         endcase
      end
   end

   dptb_calc u_calc (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_addr       (req_tdata[31:0]),
      .in_len        (req_tdata[47:32]),
      .in_req        (req_tdata[79:48]),
      .in_last       (req_tlast),
      .table_entries (table_entries_ff),
      .bb_addr       (bb_addr_ff),
      .emit_ready    (emit_ready),
      .emit_load     (emit_load),
      .res_list      (res_list)
   );

   dptb_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .res_list   (res_list),
      .load_ready (emit_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, out_item.status, out_item.mark, out_item.count,
                       out_item.addr, out_item.idx};
   assign rsp_tuser = out_item.kind;

endmodule

[rtl/core/dptb_calc.sv]
module dptb_calc import dptb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ADDR_W-1:0]     in_addr,
   input  logic [COUNT_W-1:0]    in_len,
   input  logic [LEN_W-1:0]      in_req,
   input  logic                  in_last,
   input  logic [SLOT_W-1:0]     table_entries,
   input  logic [ADDR_W-1:0]     bb_addr,
   input  logic                  emit_ready,
   output logic                  emit_load,
   output res_list_type          res_list
);

   logic                  valid_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [COUNT_W-1:0]    len_ff;
   logic [LEN_W-1:0]      req_ff;
   logic                  last_ff;

   logic [ADDR_W-1:0]     held_addr_ff,  held_addr_in;
   logic [COUNT_W-1:0]    held_count_ff, held_count_in;
   logic                  held_valid_ff, held_valid_in;
   logic [SLOT_W-1:0]     next_slot_ff,  next_slot_in;
   logic [LEN_W-1:0]      byte_total_ff, byte_total_in;
   logic                  full_ff,       full_in;

   logic                  advance;
   res_list_type          list;

   assign advance   = valid_ff && ((list.count == '0) || emit_ready);
   assign in_ready  = !valid_ff || advance;
   assign emit_load = advance && (list.count != '0);
   assign res_list  = list;

   always_comb begin
      logic [SLOT_W-1:0]  entries;
      logic               take;
      logic               drop;
      logic [ADDR_W-1:0]  end_addr;
      logic               crossing;
      logic [COUNT_W-1:0] part;
      logic               odd;
      status_type         st;
      logic [RES_CNT_W-1:0] n;

      entries = ({22'b0, table_entries} > 32'(TABLE_DEPTH)) ?
                SLOT_W'(TABLE_DEPTH) : table_entries;
      list     = '0;
      n        = '0;
      end_addr = addr_ff + {16'b0, len_ff} - 32'd1;
      crossing = addr_ff[31:16] != end_addr[31:16];
      part     = 16'd0 - addr_ff[15:0];
      odd      = req_ff[0];
      st       = ST_OK;
      drop     = 1'b0;
      take     = 1'b0;

      held_addr_in  = held_addr_ff;
      held_count_in = held_count_ff;
      held_valid_in = held_valid_ff;
      next_slot_in  = next_slot_ff;
      byte_total_in = byte_total_ff;
      full_in       = full_ff;

      if (req_ff == '0) begin
         list.item[0]  = make_status(ST_OK);
         n             = 3'd1;
         held_addr_in  = '0;
         held_count_in = '0;
         held_valid_in = 1'b0;
         next_slot_in  = '0;
         byte_total_in = '0;
         full_in       = 1'b0;
      end else begin
         if (len_ff != '0) begin
            drop = full_ff || (({1'b0, next_slot_ff} + 11'd2) > {1'b0, entries});
            take = !drop;
         end
         if (drop)
            full_in = 1'b1;
         if (take) begin
            if (held_valid_ff) begin
               list.item[n] = make_desc(next_slot_ff - 10'd1, held_addr_ff,
                                        held_count_ff, 1'b0);
               n = n + 3'd1;
            end
            if (crossing) begin
               list.item[n]  = make_desc(next_slot_ff, addr_ff, part, 1'b0);
               n             = n + 3'd1;
               held_addr_in  = addr_ff + {16'b0, part};
               held_count_in = len_ff - part;
               next_slot_in  = next_slot_ff + 10'd2;
            end else begin
               held_addr_in  = addr_ff;
               held_count_in = len_ff;
               next_slot_in  = next_slot_ff + 10'd1;
            end
            held_valid_in = 1'b1;
            byte_total_in = byte_total_ff + {16'b0, len_ff};
         end

         if (last_ff) begin
            if (full_in)
               st = ST_FULL;
            else if (byte_total_in != req_ff)
               st = ST_MISMATCH;
            else if (odd && (next_slot_in >= entries))
               st = ST_FULL;

            if (held_valid_in) begin
               list.item[n] = make_desc(next_slot_in - 10'd1, held_addr_in,
                                        held_count_in, (st == ST_OK) && !odd);
               n = n + 3'd1;
            end
            if ((st == ST_OK) && odd) begin
               list.item[n] = make_desc(next_slot_in, bb_addr, 16'd1, 1'b1);
               n = n + 3'd1;
            end
            list.item[n] = make_status(st);
            n = n + 3'd1;

            held_addr_in  = '0;
            held_count_in = '0;
            held_valid_in = 1'b0;
            next_slot_in  = '0;
            byte_total_in = '0;
            full_in       = 1'b0;
         end
      end
      list.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         addr_ff <= in_addr;
         len_ff  <= in_len;
         req_ff  <= in_req;
         last_ff <= in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_addr_ff  <= '0;
         held_count_ff <= '0;
         held_valid_ff <= 1'b0;
         next_slot_ff  <= '0;
         byte_total_ff <= '0;
         full_ff       <= 1'b0;
      end else if (advance) begin
         held_addr_ff  <= held_addr_in;
         held_count_ff <= held_count_in;
         held_valid_ff <= held_valid_in;
         next_slot_ff  <= next_slot_in;
         byte_total_ff <= byte_total_in;
         full_ff       <= full_in;
      end
   end

endmodule

[rtl/core/dptb_emit.sv]
module dptb_emit import dptb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  res_list_type res_list,
   output logic         load_ready,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_item,
   output logic         out_last
);

   result_type [MAX_RES-1:0] buf_ff;
   logic [RES_CNT_W-1:0]     cnt_ff;
   logic [RES_CNT_W-1:0]     rd_ff;
   logic                     at_last;

   assign out_valid  = cnt_ff != '0;
   assign at_last    = rd_ff == (cnt_ff - 3'd1);
   assign out_last   = at_last;
   assign out_item   = buf_ff[rd_ff];
   assign load_ready = !out_valid || (at_last && out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else if (load) begin
         cnt_ff <= res_list.count;
         rd_ff  <= '0;
      end else if (out_valid && out_ready) begin
         if (at_last) begin
            cnt_ff <= '0;
            rd_ff  <= '0;
         end else begin
            rd_ff <= rd_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         buf_ff <= res_list.item;
   end

endmodule

[rtl/core/dptb_checker.sv]
module dptb_checker import dptb_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == KIND_STATUS) |-> rsp_tlast)
      else $error("status item not last of its run");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == KIND_STATUS) |-> rsp_tdata[57:0] == '0)
      else $error("status item carries descriptor fields");

   a_desc_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == KIND_DESC) |-> rsp_tdata[59:58] == ST_OK)
      else $error("descriptor carries nonzero status");

   a_mark_then_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser[0] == KIND_DESC) && rsp_tdata[57]
      |-> !rsp_tlast)
      else $error("marked descriptor not followed by status");

endmodule

bind dma_prd_table_builder dptb_checker u_dptb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
